// ----- hw/rtl/topological_sort_levels_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the topological sort core
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_LEVELS_CORE_MACROS_SVH
`define TOPOLOGICAL_SORT_LEVELS_CORE_MACROS_SVH

// Same-cycle implication
`define TSL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tsl_pkg.sv -----
// ----------------------------------------------------------------------------
// tsl_pkg
// Widths, codes and defaults shared by the topological sort core.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int ADDR_LIMIT       = 32;   // vertex fields are 5 bits

    localparam int CMD_W    = 1;
    localparam int VERTEX_W = 5;
    localparam int VCOUNT_W = 6;
    localparam int LEVEL_W  = 6;
    localparam int DEG_W    = 6;
    localparam int LPATH_W  = 5;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SORT     = 1'b1;

endpackage

// ----- hw/rtl/tsl_ram.sv -----
// ----------------------------------------------------------------------------
// tsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/topological_sort_levels_core.sv -----
// ----------------------------------------------------------------------------
// topological_sort_levels_core
// Add edge: accepted while idle, no result. Sort with n active vertices:
// paced by one in-degree adder/decrementer visiting one matrix bit per
// cycle; one result per pop.
// Input stalls for the whole sort; output register waits on downstream.
// Reset clears the edge matrix, sets vertex_count to 32, empties the output.
// ----------------------------------------------------------------------------
module topological_sort_levels_core #(
    parameter int MAX_VERTICES = tsl_pkg::MAX_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: vertex_count
    input  logic                          cfg_write_en,
    input  logic [tsl_pkg::VCOUNT_W-1:0]  cfg_write_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tsl_pkg::CMD_W-1:0]     cmd,
    input  logic [tsl_pkg::VERTEX_W-1:0]  from_vertex,
    input  logic [tsl_pkg::VERTEX_W-1:0]  to_vertex,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tsl_pkg::VERTEX_W-1:0]  vertex,
    output logic                          vertex_valid,
    output logic [tsl_pkg::LEVEL_W-1:0]   level,
    output logic                          last,
    output logic                          complete,
    output logic [tsl_pkg::LPATH_W-1:0]   path_len
);

    import tsl_pkg::*;

    `include "topological_sort_levels_core_macros.svh"

    // Only vertices reachable through the 5-bit fields can be stored.
    localparam int NV = (MAX_VERTICES < ADDR_LIMIT) ? MAX_VERTICES : ADDR_LIMIT;
    localparam int QW = $clog2(NV);        // vertex / queue index
    localparam int CW = $clog2(NV + 1);    // counters that reach NV
    localparam int EW = QW + LEVEL_W;      // queue entry: vertex, level
    localparam logic [VCOUNT_W-1:0] NV_W = VCOUNT_W'(NV);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,      // column-major scan: in-degree of column j, queue sources
        ST_POP_CHECK,  // issue queue read if anything left
        ST_POP,        // take queue head, stage its result
        ST_SCAN,       // walk successors of the popped vertex
        ST_FINISH      // flush the staged result with the summary
    } state_t;

    state_t                 state_reg;
    logic [VCOUNT_W-1:0]    vcount_reg;
    logic [NV-1:0]          adj_reg [NV];
    logic [NV-1:0]          queued_reg;
    logic [CW-1:0]          n_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          j_reg;
    logic [CW-1:0]          head_reg;
    logic [CW-1:0]          tail_reg;
    logic [CW-1:0]          count_reg;
    logic [DEG_W-1:0]       acc_reg;
    logic [LEVEL_W-1:0]     max_level_reg;
    logic [QW-1:0]          now_reg;
    logic [LEVEL_W-1:0]     now_level_reg;
    logic                   pend_valid_reg;
    logic [QW-1:0]          pend_vertex_reg;
    logic [LEVEL_W-1:0]     pend_level_reg;

    logic                   out_valid_reg;
    logic [VERTEX_W-1:0]    out_vertex_reg;
    logic                   out_vvalid_reg;
    logic [LEVEL_W-1:0]     out_level_reg;
    logic                   out_last_reg;
    logic                   out_complete_reg;
    logic [LPATH_W-1:0]     out_lpath_reg;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [VCOUNT_W-1:0]    eff_count;
    logic [CW-1:0]          n_eff;
    logic                   in_accept;
    logic                   sort_accept;
    logic                   out_free;
    logic                   out_load;
    logic                   edge_in_range;
    logic [QW-1:0]          j_idx;
    logic [CW-1:0]          j_ahead;
    logic [QW-1:0]          row_sel;
    logic                   adj_bit;
    logic [DEG_W-1:0]       alu_a;
    logic [DEG_W-1:0]       alu_res;
    logic                   alu_zero;
    logic                   last_row;
    logic                   last_col;
    logic                   pop_more;
    logic                   pops_in_step;
    logic                   enqueue;
    logic [LEVEL_W-1:0]     enq_level;
    logic [EW-1:0]          q_wdata;
    logic [EW-1:0]          q_rdata;
    logic [QW-1:0]          rd_vertex;
    logic [LEVEL_W-1:0]     rd_level;
    logic                   q_re;
    logic                   deg_we;
    logic                   deg_re;
    logic [QW-1:0]          deg_raddr;
    logic [DEG_W-1:0]       deg_rdata;
    logic [LEVEL_W-1:0]     lp_full;

    // Counts above the store size are clamped.
    assign eff_count = (vcount_reg > NV_W) ? NV_W : vcount_reg;
    assign n_eff     = eff_count[CW-1:0];

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign sort_accept = in_accept && (cmd == CMD_SORT);
    assign out_free    = !out_valid_reg || !out_stall;

    // output register takes a new result this cycle
    assign out_load = ((state_reg == ST_POP) && pend_valid_reg && out_free) ||
                      ((state_reg == ST_FINISH) && out_free);

    assign edge_in_range = (VCOUNT_W'(from_vertex) < NV_W) &&
                           (VCOUNT_W'(to_vertex) < NV_W);

    // Row is the predecessor: counter i while counting, the popped vertex
    // while releasing successors. Column is always j.
    assign j_idx   = j_reg[QW-1:0];
    assign j_ahead = j_reg + CW'(1);
    assign row_sel = (state_reg == ST_COUNT) ? i_reg[QW-1:0] : now_reg;
    assign adj_bit = adj_reg[row_sel][j_idx];

    // Shared in-degree unit: accumulate while counting, saturating
    // decrement while releasing.
    assign alu_a    = (state_reg == ST_COUNT) ? acc_reg : deg_rdata;
    assign alu_res  = (state_reg == ST_COUNT) ? (alu_a + DEG_W'(adj_bit))
                                              : (alu_a - DEG_W'(alu_a != '0));
    assign alu_zero = (alu_res == '0);

    assign last_row = (i_reg == n_reg - CW'(1));
    assign last_col = (j_reg == n_reg - CW'(1));
    assign pop_more = (head_reg < tail_reg) && (head_reg < n_reg);
    assign pops_in_step = (head_reg <= tail_reg) && (count_reg == head_reg);

    // A source is queued once its column total is zero; a successor once
    // its last pending edge is released and it has no level yet.
    assign enqueue = ((state_reg == ST_COUNT) && last_row && alu_zero) ||
                     ((state_reg == ST_SCAN) && adj_bit && alu_zero &&
                      !queued_reg[j_idx] && (tail_reg < n_reg));
    assign enq_level = (state_reg == ST_COUNT) ? LEVEL_W'(1)
                                               : (now_level_reg + LEVEL_W'(1));
    assign q_wdata   = {j_idx, enq_level};
    assign q_re      = (state_reg == ST_POP_CHECK) && pop_more;
    assign rd_vertex = q_rdata[EW-1:LEVEL_W];
    assign rd_level  = q_rdata[LEVEL_W-1:0];
    assign lp_full   = max_level_reg - LEVEL_W'(1);

    // Ready queue: FIFO order, written at tail, read at head.
    tsl_ram #(
        .WIDTH (EW),
        .DEPTH (NV)
    ) u_ready_queue (
        .clk   (clk),
        .we    (enqueue),
        .waddr (tail_reg[QW-1:0]),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg[QW-1:0]),
        .rdata (q_rdata)
    );

    // In-degree store: written by every sort before it is read. While
    // releasing, column j+1 is fetched during column j (column 0 during
    // the pop), so the registered data lines up with j. The write at j
    // never hits the column being fetched.
    assign deg_we    = ((state_reg == ST_COUNT) && last_row) ||
                       ((state_reg == ST_SCAN) && adj_bit);
    assign deg_re    = (state_reg == ST_POP) || (state_reg == ST_SCAN);
    assign deg_raddr = (state_reg == ST_SCAN) ? j_ahead[QW-1:0] : '0;

    tsl_ram #(
        .WIDTH (DEG_W),
        .DEPTH (NV)
    ) u_in_degree (
        .clk   (clk),
        .we    (deg_we),
        .waddr (j_idx),
        .wdata (alu_res),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer, edge matrix and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vcount_reg     <= VCOUNT_RESET;
            for (int r = 0; r < NV; r++)
            begin
                adj_reg[r] <= '0;
            end
            queued_reg       <= '0;
            n_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            acc_reg          <= '0;
            max_level_reg    <= '0;
            now_reg          <= '0;
            now_level_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            pend_vertex_reg  <= '0;
            pend_level_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_vertex_reg   <= '0;
            out_vvalid_reg   <= 1'b0;
            out_level_reg    <= '0;
            out_last_reg     <= 1'b0;
            out_complete_reg <= 1'b0;
            out_lpath_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                vcount_reg <= cfg_write_data;
            end

            // downstream took the result and nothing replaces it
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (cmd == CMD_ADD_EDGE)
                        begin
                            if (edge_in_range)
                            begin
                                adj_reg[from_vertex[QW-1:0]][to_vertex[QW-1:0]] <= 1'b1;
                            end
                        end
                        else
                        begin
                            n_reg          <= n_eff;
                            i_reg          <= '0;
                            j_reg          <= '0;
                            head_reg       <= '0;
                            tail_reg       <= '0;
                            count_reg      <= '0;
                            acc_reg        <= '0;
                            max_level_reg  <= '0;
                            queued_reg     <= '0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= (n_eff == '0) ? ST_FINISH : ST_COUNT;
                        end
                    end
                end

                ST_COUNT:
                begin
                    if (last_row)
                    begin
                        acc_reg <= '0;
                        i_reg   <= '0;
                        j_reg   <= j_reg + CW'(1);
                        if (last_col)
                        begin
                            state_reg <= ST_POP_CHECK;
                        end
                    end
                    else
                    begin
                        acc_reg <= alu_res;
                        i_reg   <= i_reg + CW'(1);
                    end
                    if (enqueue)
                    begin
                        queued_reg[j_idx] <= 1'b1;
                        tail_reg          <= tail_reg + CW'(1);
                    end
                end

                ST_POP_CHECK:
                begin
                    state_reg <= pop_more ? ST_POP : ST_FINISH;
                end

                ST_POP:
                begin
                    // the staged result can only move on once the
                    // output register is free
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg    <= 1'b1;
                            out_vertex_reg   <= VERTEX_W'(pend_vertex_reg);
                            out_vvalid_reg   <= 1'b1;
                            out_level_reg    <= pend_level_reg;
                            out_last_reg     <= 1'b0;
                            out_complete_reg <= 1'b0;
                            out_lpath_reg    <= '0;
                        end
                        pend_valid_reg  <= 1'b1;
                        pend_vertex_reg <= rd_vertex;
                        pend_level_reg  <= rd_level;
                        now_reg         <= rd_vertex;
                        now_level_reg   <= rd_level;
                        if (rd_level > max_level_reg)
                        begin
                            max_level_reg <= rd_level;
                        end
                        count_reg <= count_reg + CW'(1);
                        head_reg  <= head_reg + CW'(1);
                        j_reg     <= '0;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (enqueue)
                    begin
                        queued_reg[j_idx] <= 1'b1;
                        tail_reg          <= tail_reg + CW'(1);
                    end
                    j_reg <= j_reg + CW'(1);
                    if (last_col)
                    begin
                        state_reg <= ST_POP_CHECK;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        // final result carries the summary; with nothing
                        // sorted it is a lone empty result
                        out_valid_reg    <= 1'b1;
                        out_vertex_reg   <= pend_valid_reg ? VERTEX_W'(pend_vertex_reg) : '0;
                        out_vvalid_reg   <= pend_valid_reg;
                        out_level_reg    <= pend_valid_reg ? pend_level_reg : '0;
                        out_last_reg     <= 1'b1;
                        out_complete_reg <= (count_reg == n_reg);
                        out_lpath_reg    <= pend_valid_reg ? lp_full[LPATH_W-1:0] : '0;
                        pend_valid_reg   <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex       = out_vertex_reg;
    assign vertex_valid = out_vvalid_reg;
    assign level        = out_level_reg;
    assign last         = out_last_reg;
    assign complete     = out_complete_reg;
    assign path_len     = out_lpath_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TSL_ASSERT_IMPLY(a_tail_bound, state_reg != ST_IDLE, tail_reg <= n_reg, "tail past count")
    `TSL_ASSERT_IMPLY(a_head_count, state_reg != ST_IDLE, pops_in_step, "pop bookkeeping")
    `TSL_ASSERT_NEXT(a_sort_start, sort_accept, state_reg != ST_IDLE, "sort did not start")

endmodule
